### hdl/lcra_pkg.sv
// ============================================================================
// lcra_pkg
// Shared sizes, neighbor step tables and controller/datapath interface types
// for the largest eight-connected region area core.
// ============================================================================
package lcra_pkg;

    // Grid bounds
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CELLS  = 2 ** ADDR_W;
    localparam int TOP_W  = ADDR_W + 1;

    // Result and register widths fixed by the interface
    localparam int AREA_W    = 13;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Width for size and coordinate arithmetic (covers a 1024 limit plus one)
    localparam int DIM_W = 12;

    // Neighbor counter
    localparam int NBR_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

    localparam logic [CFG_W-1:0] GRID_ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] GRID_COLS_RESET = 7'd64;

    // One coordinate step
    typedef enum logic [1:0] {
        DELTA_ZERO = 2'b00,
        DELTA_POS  = 2'b01,
        DELTA_NEG  = 2'b10
    } delta_t;

    // Row step of neighbor k: {-1,-1,0,1,1,1,0,-1}
    function automatic delta_t step_row(logic [NBR_W-1:0] k);
        delta_t d;
        case (k)
            3'd0, 3'd1, 3'd7: d = DELTA_NEG;
            3'd3, 3'd4, 3'd5: d = DELTA_POS;
            default:          d = DELTA_ZERO;
        endcase
        return d;
    endfunction

    // Column step of neighbor k: {0,1,1,1,0,-1,-1,-1}
    function automatic delta_t step_col(logic [NBR_W-1:0] k);
        delta_t d;
        case (k)
            3'd1, 3'd2, 3'd3: d = DELTA_POS;
            3'd5, 3'd6, 3'd7: d = DELTA_NEG;
            default:          d = DELTA_ZERO;
        endcase
        return d;
    endfunction

    // Clamp a size register to 1..limit
    function automatic logic [DIM_W-1:0] used_size(logic [CFG_W-1:0] v,
                                                   logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] w;
        w = DIM_W'(v);
        if (w == '0)
            return DIM_W'(1);
        else if (w > limit)
            return limit;
        else
            return w;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // write the accepted cell, advance the load position
        logic scan_rd;     // read the cell at the scan position
        logic scan_chk;    // start a region if the scanned cell is fresh
        logic scan_adv;    // advance the scan position
        logic pop;         // drop the top of the walk stack, read it
        logic cur_take;    // latch the popped cell, count it
        logic nbr_chk;     // mark and push the neighbor if fresh
        logic k_adv;       // advance to the next neighbor direction
        logic region_end;  // fold the region count into the best area
        logic out_take;    // load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic load_last;   // load position is the last cell of the grid
        logic scan_last;   // scan position is the last cell of the grid
        logic hit;         // cell just read is set and not yet visited
        logic stack_empty;
        logic nbr_ok;      // current neighbor lies inside the grid
        logic k_last;      // current direction is the last one
        logic out_free;    // result register can take a new value
    } stat_t;

endpackage

### hdl/lcra_ram.sv
// ============================================================================
// lcra_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module lcra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lcra_ctrl.sv
// ============================================================================
// lcra_ctrl
// Sequencer for loading, scanning and stack-based flood fill.
// ============================================================================
module lcra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  lcra_pkg::stat_t stat,
    output lcra_pkg::cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_LOAD     = 8'b0000_0001,
        S_SCAN_RD  = 8'b0000_0010,
        S_SCAN_CHK = 8'b0000_0100,
        S_POP      = 8'b0000_1000,
        S_POP_WAIT = 8'b0001_0000,
        S_NBR_RD   = 8'b0010_0000,
        S_NBR_CHK  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && stat.load_last)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_POP;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_POP:
            begin
                if (stat.stack_empty)
                begin
                    cmd.region_end = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.scan_adv = 1'b1;
                        state_next   = S_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                cmd.cur_take = 1'b1;
                state_next   = S_NBR_RD;
            end
            S_NBR_RD:
            begin
                if (stat.nbr_ok)
                begin
                    state_next = S_NBR_CHK;
                end
                else if (stat.k_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.k_adv = 1'b1;
                end
            end
            S_NBR_CHK:
            begin
                cmd.nbr_chk = 1'b1;
                if (stat.k_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.k_adv  = 1'b1;
                    state_next = S_NBR_RD;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_take = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

### hdl/lcra_dp.sv
// ============================================================================
// lcra_dp
// Datapath: size registers, load and scan positions, cell/visited RAM,
// walk stack RAM, neighbor address logic, region and best counters.
// ============================================================================
module lcra_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lcra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcra_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               cell_is_set,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [lcra_pkg::AREA_W-1:0]        largest_area,
    input  lcra_pkg::cmd_t                     cmd,
    output lcra_pkg::stat_t                    stat
);

    localparam int ROW_W  = lcra_pkg::ROW_W;
    localparam int COL_W  = lcra_pkg::COL_W;
    localparam int ADDR_W = lcra_pkg::ADDR_W;
    localparam int TOP_W  = lcra_pkg::TOP_W;
    localparam int DIM_W  = lcra_pkg::DIM_W;
    localparam int AREA_W = lcra_pkg::AREA_W;
    localparam int NBR_W  = lcra_pkg::NBR_W;

    logic [lcra_pkg::CFG_W-1:0] grid_rows_reg, grid_rows_next;
    logic [lcra_pkg::CFG_W-1:0] grid_cols_reg, grid_cols_next;
    logic [ROW_W-1:0]  load_row_reg, load_row_next;
    logic [COL_W-1:0]  load_col_reg, load_col_next;
    logic [ROW_W-1:0]  scan_row_reg, scan_row_next;
    logic [COL_W-1:0]  scan_col_reg, scan_col_next;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [NBR_W-1:0]  k_reg, k_next;
    logic [AREA_W-1:0] region_reg, region_next;
    logic [AREA_W-1:0] best_reg, best_next;
    logic              out_valid_reg, out_valid_next;
    logic [AREA_W-1:0] area_reg, area_next;

    logic [DIM_W-1:0]  rows_used, cols_used;
    logic              load_row_last, load_col_last;
    logic              scan_row_last, scan_col_last;
    logic [ADDR_W-1:0] load_addr, scan_addr, nbr_addr;

    // Neighbor address
    logic [DIM_W-1:0] cr_ext, cc_ext, nr_ext, nc_ext;
    logic             row_ok, col_ok;

    // RAM ports
    logic              cell_we;
    logic [ADDR_W-1:0] cell_waddr, cell_raddr;
    logic [1:0]        cell_wdata, cell_rdata;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic              hit, push;

    assign rows_used = lcra_pkg::used_size(grid_rows_reg, DIM_W'(lcra_pkg::MAX_ROWS));
    assign cols_used = lcra_pkg::used_size(grid_cols_reg, DIM_W'(lcra_pkg::MAX_COLS));

    assign load_row_last = (DIM_W'(load_row_reg) == rows_used - DIM_W'(1));
    assign load_col_last = (DIM_W'(load_col_reg) == cols_used - DIM_W'(1));
    assign scan_row_last = (DIM_W'(scan_row_reg) == rows_used - DIM_W'(1));
    assign scan_col_last = (DIM_W'(scan_col_reg) == cols_used - DIM_W'(1));

    assign load_addr = {load_row_reg, load_col_reg};
    assign scan_addr = {scan_row_reg, scan_col_reg};

    always_comb
    begin
        cr_ext = DIM_W'(cur_reg[ADDR_W-1:COL_W]);
        cc_ext = DIM_W'(cur_reg[COL_W-1:0]);
        case (lcra_pkg::step_row(k_reg))
            lcra_pkg::DELTA_NEG:
            begin
                nr_ext = cr_ext - DIM_W'(1);
                row_ok = (cr_ext != '0);
            end
            lcra_pkg::DELTA_POS:
            begin
                nr_ext = cr_ext + DIM_W'(1);
                row_ok = (nr_ext < rows_used);
            end
            default:
            begin
                nr_ext = cr_ext;
                row_ok = 1'b1;
            end
        endcase
        case (lcra_pkg::step_col(k_reg))
            lcra_pkg::DELTA_NEG:
            begin
                nc_ext = cc_ext - DIM_W'(1);
                col_ok = (cc_ext != '0);
            end
            lcra_pkg::DELTA_POS:
            begin
                nc_ext = cc_ext + DIM_W'(1);
                col_ok = (nc_ext < cols_used);
            end
            default:
            begin
                nc_ext = cc_ext;
                col_ok = 1'b1;
            end
        endcase
    end

    assign nbr_addr = {nr_ext[ROW_W-1:0], nc_ext[COL_W-1:0]};

    // Entry layout: bit 1 visited, bit 0 set
    assign hit  = cell_rdata[0] & ~cell_rdata[1];
    assign push = (cmd.scan_chk | cmd.nbr_chk) & hit;

    always_comb
    begin
        cell_we    = cmd.load | push;
        cell_waddr = cmd.load ? load_addr : (cmd.scan_chk ? scan_addr : nbr_addr);
        cell_wdata = cmd.load ? {1'b0, cell_is_set} : 2'b11;
        cell_raddr = cmd.scan_rd ? scan_addr : nbr_addr;
        stk_we     = push;
        stk_waddr  = top_reg[ADDR_W-1:0];
        stk_wdata  = cmd.scan_chk ? scan_addr : nbr_addr;
        stk_raddr  = top_reg[ADDR_W-1:0] - ADDR_W'(1);
    end

    lcra_ram #(
        .WIDTH (2),
        .DEPTH (lcra_pkg::CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    lcra_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (lcra_pkg::CELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        scan_row_next  = scan_row_reg;
        scan_col_next  = scan_col_reg;
        top_next       = top_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        region_next    = region_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg & out_stall;
        area_next      = area_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                lcra_pkg::REG_GRID_ROWS: grid_rows_next = cfg_data;
                lcra_pkg::REG_GRID_COLS: grid_cols_next = cfg_data;
                default:                 grid_rows_next = grid_rows_reg;
            endcase
            load_row_next = '0;
            load_col_next = '0;
        end
        else if (cmd.load)
        begin
            if (load_col_last)
            begin
                load_col_next = '0;
                load_row_next = load_row_reg + ROW_W'(1);
            end
            else
            begin
                load_col_next = load_col_reg + COL_W'(1);
            end
            if (load_row_last && load_col_last)
            begin
                load_row_next = '0;
                scan_row_next = '0;
                scan_col_next = '0;
                best_next     = '0;
            end
        end

        if (cmd.scan_adv)
        begin
            if (scan_col_last)
            begin
                scan_col_next = '0;
                scan_row_next = scan_row_reg + ROW_W'(1);
            end
            else
            begin
                scan_col_next = scan_col_reg + COL_W'(1);
            end
        end

        if (push)
        begin
            top_next = top_reg + TOP_W'(1);
        end
        if (cmd.scan_chk && hit)
        begin
            region_next = '0;
        end
        if (cmd.pop)
        begin
            top_next = top_reg - TOP_W'(1);
        end
        if (cmd.cur_take)
        begin
            cur_next    = stk_rdata;
            region_next = region_reg + AREA_W'(1);
            k_next      = '0;
        end
        if (cmd.k_adv)
        begin
            k_next = k_reg + NBR_W'(1);
        end
        if (cmd.region_end && (region_reg > best_reg))
        begin
            best_next = region_reg;
        end
        if (cmd.out_take)
        begin
            out_valid_next = 1'b1;
            area_next      = best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= lcra_pkg::GRID_ROWS_RESET;
            grid_cols_reg <= lcra_pkg::GRID_COLS_RESET;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            top_reg       <= '0;
            k_reg         <= '0;
            region_reg    <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            top_reg       <= top_next;
            k_reg         <= k_next;
            region_reg    <= region_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        area_reg <= area_next;
    end

    assign out_valid    = out_valid_reg;
    assign largest_area = area_reg;

    always_comb
    begin
        stat.load_last   = load_row_last & load_col_last;
        stat.scan_last   = scan_row_last & scan_col_last;
        stat.hit         = hit;
        stat.stack_empty = (top_reg == '0);
        stat.nbr_ok      = row_ok & col_ok;
        stat.k_last      = (k_reg == {NBR_W{1'b1}});
        stat.out_free    = ~out_valid_reg | ~out_stall;
    end

endmodule

### hdl/largest_connected_region_area_core.sv
// ============================================================================
// largest_connected_region_area_core
// Largest eight-connected region of a binary grid, one cell per transfer.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / cell_is_set) takes the grid in
//   row-major order, one cell per transfer, one transfer per cycle while
//   loading. The grid size comes from grid_rows (index 0) and grid_cols
//   (index 1) on the cfg_we / cfg_index / cfg_data port; 0 counts as 1 and
//   anything above 64 as 64. Any register write restarts loading at cell 0.
//   After the last cell of a grid the core raises in_stall and runs the
//   flood fill: a scan over every cell (a read state, then a check state)
//   and, per set cell, one stack pop, one fetch and up to 8 neighbor
//   probes, all through one cell/visited RAM and one walk-stack RAM.
//   The result transfer then goes out on out_valid / out_stall /
//   largest_area, one transfer per grid.
//   The result sits in an output register; the core returns to loading as
//   soon as that register is free, so a stalled receiver only holds the
//   core when a second result is ready. Reset selects a 64 x 64 grid and
//   empties the output register; no clearing pass is needed, since each
//   loaded cell also clears its visited mark.
// ============================================================================
module largest_connected_region_area_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lcra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcra_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cell_is_set,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lcra_pkg::AREA_W-1:0]        largest_area
);

    // Command and status between sequencer and datapath
    lcra_pkg::cmd_t  cmd;
    lcra_pkg::stat_t stat;

    lcra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcra_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_is_set  (cell_is_set),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .largest_area (largest_area),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
